/* hdl/isq_pkg.sv */
// ----------------------------------------------------------------------------
// isq_pkg
// Shared constants, request and status codes, and the command and status
// bundles that pass between the sequence store controller and datapath.
// ----------------------------------------------------------------------------
package isq_pkg;

	// Storage geometry
	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// Channel field widths
	localparam int REQ_W    = 3;
	localparam int POS_W    = 5;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd4;
	localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd5;
	localparam logic [REQ_W-1:0] REQ_GET        = 3'd6;
	localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd7;

	// Status codes
	localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STS_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] STS_FULL  = 2'd3;

	// Datapath store operations
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_OPEN  = 2'd1;
	localparam logic [1:0] OP_CLOSE = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// Controller to datapath command
	typedef struct packed {
		logic                  load;
		logic [1:0]            op;
		logic [IDX_W-1:0]      at;
		logic                  rd_en;
		logic [DATA_WIDTH-1:0] word;
	} isq_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [CNT_W-1:0] count;
	} isq_sts_t;

endpackage

/* hdl/isq_req_if.sv */
// ----------------------------------------------------------------------------
// isq_req_if
// Request channel: valid/ready handshake with request type, position and word.
// ----------------------------------------------------------------------------
interface isq_req_if;
	logic                          valid;
	logic                          ready;
	logic [isq_pkg::REQ_W-1:0]     req_type;
	logic [isq_pkg::POS_W-1:0]     position;
	logic [isq_pkg::WORD_W-1:0]    data_in;

	modport source (output valid, output req_type, output position, output data_in,
		input ready);
	modport sink (input valid, input req_type, input position, input data_in,
		output ready);
endinterface

/* hdl/isq_rsp_if.sv */
// ----------------------------------------------------------------------------
// isq_rsp_if
// Response channel: valid/ready handshake with read data, status and count.
// ----------------------------------------------------------------------------
interface isq_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [isq_pkg::WORD_W-1:0]    read_data;
	logic [isq_pkg::STATUS_W-1:0]  status;
	logic [isq_pkg::COUNT_W-1:0]   element_count;

	modport source (output valid, output read_data, output status, output element_count,
		input ready);
	modport sink (input valid, input read_data, input status, input element_count,
		output ready);
endinterface

/* hdl/isq_ctrl.sv */
// ----------------------------------------------------------------------------
// isq_ctrl
// Request controller: checks each request against the current count, issues
// one store command per transfer and holds the response until it is taken.
// ----------------------------------------------------------------------------
module isq_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [isq_pkg::REQ_W-1:0]       req_type,
	input  logic [isq_pkg::POS_W-1:0]       position,
	input  logic [isq_pkg::WORD_W-1:0]      data_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [isq_pkg::STATUS_W-1:0]    status,
	output isq_pkg::isq_cmd_t               cmd,
	input  isq_pkg::isq_sts_t               sts
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RESP = 1'b1;

	logic                           state_q;
	logic [isq_pkg::STATUS_W-1:0]   status_q;
	logic                           accept;
	logic [isq_pkg::STATUS_W-1:0]   status_d;
	logic [1:0]                     op_d;
	logic [isq_pkg::IDX_W-1:0]      at_d;
	logic                           rd_d;
	logic [isq_pkg::POS_W-1:0]      cnt_ext;
	logic                           full;

	// Accept a new request whenever the response slot is free or draining
	assign in_ready  = (state_q == S_IDLE) || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == S_RESP);
	assign status    = status_q;

	assign cnt_ext = isq_pkg::POS_W'(sts.count);
	assign full    = (sts.count >= isq_pkg::CNT_W'(isq_pkg::CAPACITY));

	// Decode request and check it against the current count
	always_comb begin
		status_d = isq_pkg::STS_OK;
		op_d     = isq_pkg::OP_NONE;
		at_d     = '0;
		rd_d     = 1'b0;
		unique case (req_type)
			isq_pkg::REQ_PUSH_BACK: begin
				if (full) begin
					status_d = isq_pkg::STS_FULL;
				end else begin
					op_d = isq_pkg::OP_OPEN;
					at_d = sts.count[isq_pkg::IDX_W-1:0];
				end
			end
			isq_pkg::REQ_PUSH_FRONT: begin
				if (full) begin
					status_d = isq_pkg::STS_FULL;
				end else begin
					op_d = isq_pkg::OP_OPEN;
				end
			end
			isq_pkg::REQ_POP_FRONT: begin
				if (sts.count == '0) begin
					status_d = isq_pkg::STS_EMPTY;
				end else begin
					op_d = isq_pkg::OP_CLOSE;
				end
			end
			isq_pkg::REQ_POP_BACK: begin
				if (sts.count == '0) begin
					status_d = isq_pkg::STS_EMPTY;
				end else begin
					op_d = isq_pkg::OP_CLOSE;
					at_d = isq_pkg::IDX_W'(sts.count - isq_pkg::CNT_W'(1));
				end
			end
			isq_pkg::REQ_INSERT: begin
				if (position > cnt_ext) begin
					status_d = isq_pkg::STS_RANGE;
				end else if (full) begin
					status_d = isq_pkg::STS_FULL;
				end else begin
					op_d = isq_pkg::OP_OPEN;
					at_d = position[isq_pkg::IDX_W-1:0];
				end
			end
			isq_pkg::REQ_REMOVE: begin
				if (position >= cnt_ext) begin
					status_d = isq_pkg::STS_RANGE;
				end else begin
					op_d = isq_pkg::OP_CLOSE;
					at_d = position[isq_pkg::IDX_W-1:0];
				end
			end
			isq_pkg::REQ_GET: begin
				if (position >= cnt_ext) begin
					status_d = isq_pkg::STS_RANGE;
				end else begin
					rd_d = 1'b1;
					at_d = position[isq_pkg::IDX_W-1:0];
				end
			end
			isq_pkg::REQ_CLEAR: begin
				op_d = isq_pkg::OP_CLEAR;
			end
			default: begin
				op_d = isq_pkg::OP_NONE;
			end
		endcase
	end

	// Drive the datapath command
	always_comb begin
		cmd.load  = accept;
		cmd.op    = op_d;
		cmd.at    = at_d;
		cmd.rd_en = rd_d;
		cmd.word  = data_in[isq_pkg::DATA_WIDTH-1:0];
	end

	// Advance the response state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else if (accept) begin
			state_q <= S_RESP;
		end else if (out_ready) begin
			state_q <= S_IDLE;
		end
	end

	// Hold the status of the last transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
		end
	end

endmodule

/* hdl/isq_datapath.sv */
// ----------------------------------------------------------------------------
// isq_datapath
// Register-cell element store with parallel shift for gap open and close,
// the element counter and the registered read data.
// ----------------------------------------------------------------------------
module isq_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  isq_pkg::isq_cmd_t             cmd,
	output isq_pkg::isq_sts_t             sts,
	output logic [isq_pkg::WORD_W-1:0]    read_data
);

	logic [isq_pkg::DATA_WIDTH-1:0] store_q [isq_pkg::CAPACITY];
	logic [isq_pkg::CNT_W-1:0]      count_q;
	logic [isq_pkg::DATA_WIDTH-1:0] rd_q;

	assign sts.count = count_q;
	assign read_data = isq_pkg::WORD_W'(rd_q);

	// Shift cells at and above the gap position
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < isq_pkg::CAPACITY; i++) begin
				if (cmd.op == isq_pkg::OP_OPEN) begin
					if (i == int'(cmd.at)) begin
						store_q[i] <= cmd.word;
					end else if (i > int'(cmd.at)) begin
						store_q[i] <= store_q[i-1];
					end
				end else if (cmd.op == isq_pkg::OP_CLOSE) begin
					if (i >= int'(cmd.at) && i < isq_pkg::CAPACITY - 1) begin
						store_q[i] <= store_q[i+1];
					end
				end
			end
		end
	end

	// Update the element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load) begin
			unique case (cmd.op)
				isq_pkg::OP_OPEN:  count_q <= count_q + isq_pkg::CNT_W'(1);
				isq_pkg::OP_CLOSE: count_q <= count_q - isq_pkg::CNT_W'(1);
				isq_pkg::OP_CLEAR: count_q <= '0;
				default:           count_q <= count_q;
			endcase
		end
	end

	// Capture the read word, zero when no get
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_q <= cmd.rd_en ? store_q[cmd.at] : '0;
		end
	end

endmodule

/* hdl/indexed_sequence_store_core.sv */
// Response: a response is valid in the cycle after its request transfer.
// Throughput: one request per cycle while responses are taken; all cells shift in parallel in the
// register-cell store, and a new request is taken while the response drains.
// Reset: arst_n clears the element count and the response state; the cell
// contents are left as they are and only read below the count.
// ----------------------------------------------------------------------------
// indexed_sequence_store_core
// Ordered store of up to CAPACITY words with push, pop, insert, remove, get
// and clear, built as a request controller and a register-cell datapath.
// ----------------------------------------------------------------------------
module indexed_sequence_store_core (
	input  logic       clk,
	input  logic       arst_n,
	isq_req_if.sink    req,
	isq_rsp_if.source  rsp
);

	localparam logic [isq_pkg::COUNT_W-1:0] CAP_CNT = isq_pkg::COUNT_W'(isq_pkg::CAPACITY);

	isq_pkg::isq_cmd_t cmd;
	isq_pkg::isq_sts_t sts;

	isq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.req_type  (req.req_type),
		.position  (req.position),
		.data_in   (req.data_in),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (rsp.status),
		.cmd       (cmd),
		.sts       (sts)
	);

	isq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.read_data (rsp.read_data)
	);

	assign rsp.element_count = isq_pkg::COUNT_W'(sts.count);

	// Count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.element_count <= CAP_CNT)
		else $error("element count above capacity");

	// Clear transfer empties the store
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.req_type == isq_pkg::REQ_CLEAR)
		|=> (rsp.valid && rsp.element_count == '0 && rsp.status == isq_pkg::STS_OK))
		else $error("clear did not empty the store");

	// Push on a full store reports full and keeps the count
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && rsp.element_count == CAP_CNT
		&& (req.req_type == isq_pkg::REQ_PUSH_BACK || req.req_type == isq_pkg::REQ_PUSH_FRONT))
		|=> (rsp.status == isq_pkg::STS_FULL && rsp.element_count == CAP_CNT))
		else $error("push on full store not flagged");

	// Failed requests return no read data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != isq_pkg::STS_OK) |-> (rsp.read_data == '0))
		else $error("read data on failed request");

endmodule

/* tb/tb_indexed_sequence_store_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_sequence_store_core
// Self-checking bench for the indexed sequence store. A directed table covers
// empty, full and out-of-range requests and the field extremes. Random
// request streams follow, alternating between growing and shrinking the
// sequence. An internal copy of the sequence predicts every response, and
// both channels idle in random bursts until the last CALM_ITEMS requests.
// ----------------------------------------------------------------------------
module tb_indexed_sequence_store_core;

	localparam int RAND_ITEMS = 1950;
	localparam int CALM_ITEMS = 200;

	typedef struct packed {
		logic [isq_pkg::WORD_W-1:0]   read_data;
		logic [isq_pkg::STATUS_W-1:0] status;
		logic [isq_pkg::COUNT_W-1:0]  element_count;
	} seq_outcome_t;

	typedef struct {
		logic [isq_pkg::REQ_W-1:0]  req_type;
		logic [isq_pkg::POS_W-1:0]  position;
		logic [isq_pkg::WORD_W-1:0] data_in;
		int                         reps;
		bit                         rnd_data;
		bit                         typed;
		seq_outcome_t               want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	isq_req_if req_ch ();
	isq_rsp_if rsp_ch ();

	indexed_sequence_store_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the sequence
	logic [isq_pkg::WORD_W-1:0] seq_words [isq_pkg::CAPACITY];
	int unsigned                seq_len;
	seq_outcome_t               pending_q [$];
	int                         mismatch_count;
	int                         status_hits [4];
	int                         full_hits;
	bit                         idle_on;

	// Directed requests; typed rows carry an expectation read off by hand
	stim_row_t stim_rows [25] = '{
		'{isq_pkg::REQ_POP_FRONT,  5'd0,  32'h0,         1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_EMPTY, 5'd0}},
		'{isq_pkg::REQ_POP_BACK,   5'd0,  32'h0,         1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_EMPTY, 5'd0}},
		'{isq_pkg::REQ_REMOVE,     5'd0,  32'h0,         1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_RANGE, 5'd0}},
		'{isq_pkg::REQ_GET,        5'd0,  32'h0,         1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_RANGE, 5'd0}},
		'{isq_pkg::REQ_INSERT,     5'd1,  32'hFFFF_FFFF, 1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_RANGE, 5'd0}},
		'{isq_pkg::REQ_INSERT,     5'd0,  32'hFFFF_FFFF, 1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_OK, 5'd1}},
		'{isq_pkg::REQ_PUSH_FRONT, 5'd31, 32'h0,         1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_OK, 5'd2}},
		'{isq_pkg::REQ_PUSH_BACK,  5'd0,  32'h0,         13, 1'b1, 1'b0,
			{32'h0, isq_pkg::STS_OK, 5'd0}},
		'{isq_pkg::REQ_GET,        5'd0,  32'h0,         1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_OK, 5'd15}},
		'{isq_pkg::REQ_GET,        5'd1,  32'h0,         1,  1'b0, 1'b1,
			{32'hFFFF_FFFF, isq_pkg::STS_OK, 5'd15}},
		'{isq_pkg::REQ_INSERT,     5'd15, 32'hA5A5_A5A5, 1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_OK, 5'd16}},
		'{isq_pkg::REQ_GET,        5'd15, 32'h0,         1,  1'b0, 1'b1,
			{32'hA5A5_A5A5, isq_pkg::STS_OK, 5'd16}},
		'{isq_pkg::REQ_PUSH_BACK,  5'd0,  32'h1234_5678, 1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_FULL, 5'd16}},
		'{isq_pkg::REQ_PUSH_FRONT, 5'd0,  32'h1234_5678, 1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_FULL, 5'd16}},
		'{isq_pkg::REQ_INSERT,     5'd16, 32'h1234_5678, 1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_FULL, 5'd16}},
		'{isq_pkg::REQ_INSERT,     5'd17, 32'h1234_5678, 1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_RANGE, 5'd16}},
		'{isq_pkg::REQ_GET,        5'd16, 32'h0,         1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_RANGE, 5'd16}},
		'{isq_pkg::REQ_REMOVE,     5'd31, 32'h0,         1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_RANGE, 5'd16}},
		'{isq_pkg::REQ_REMOVE,     5'd7,  32'h0,         1,  1'b0, 1'b0,
			{32'h0, isq_pkg::STS_OK, 5'd0}},
		'{isq_pkg::REQ_POP_FRONT,  5'd0,  32'h0,         1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_OK, 5'd14}},
		'{isq_pkg::REQ_POP_BACK,   5'd0,  32'h0,         1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_OK, 5'd13}},
		'{isq_pkg::REQ_INSERT,     5'd5,  32'h5A5A_5A5A, 1,  1'b0, 1'b0,
			{32'h0, isq_pkg::STS_OK, 5'd0}},
		'{isq_pkg::REQ_GET,        5'd5,  32'h0,         1,  1'b0, 1'b0,
			{32'h0, isq_pkg::STS_OK, 5'd0}},
		'{isq_pkg::REQ_CLEAR,      5'd0,  32'h0,         1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_OK, 5'd0}},
		'{isq_pkg::REQ_CLEAR,      5'd31, 32'hFFFF_FFFF, 1,  1'b0, 1'b1,
			{32'h0, isq_pkg::STS_OK, 5'd0}}
	};

	// Shift entries up from the given slot and place the word there
	function automatic void open_gap(int unsigned at, logic [isq_pkg::WORD_W-1:0] word);
		for (int unsigned j = seq_len; j > at; j--)
			seq_words[j] = seq_words[j-1];
		seq_words[at] = isq_pkg::WORD_W'(word[isq_pkg::DATA_WIDTH-1:0]);
		seq_len++;
	endfunction

	// Shift entries down over the given slot
	function automatic void close_gap(int unsigned at);
		for (int unsigned j = at; j + 1 < seq_len; j++)
			seq_words[j] = seq_words[j+1];
		seq_len--;
	endfunction

	// Apply one request to the shadow sequence and return its response
	function automatic seq_outcome_t apply_request(logic [isq_pkg::REQ_W-1:0] req_type,
			logic [isq_pkg::POS_W-1:0] position, logic [isq_pkg::WORD_W-1:0] data_in);
		seq_outcome_t res;
		int unsigned  pos;
		res = '0;
		res.status = isq_pkg::STS_OK;
		pos = int'(position);
		case (req_type)
			isq_pkg::REQ_PUSH_BACK, isq_pkg::REQ_PUSH_FRONT: begin
				if (seq_len >= isq_pkg::CAPACITY)
					res.status = isq_pkg::STS_FULL;
				else
					open_gap((req_type == isq_pkg::REQ_PUSH_BACK) ? seq_len : 0, data_in);
			end
			isq_pkg::REQ_POP_FRONT, isq_pkg::REQ_POP_BACK: begin
				if (seq_len == 0)
					res.status = isq_pkg::STS_EMPTY;
				else
					close_gap((req_type == isq_pkg::REQ_POP_FRONT) ? 0 : seq_len - 1);
			end
			isq_pkg::REQ_INSERT: begin
				if (pos > seq_len)
					res.status = isq_pkg::STS_RANGE;
				else if (seq_len >= isq_pkg::CAPACITY)
					res.status = isq_pkg::STS_FULL;
				else
					open_gap(pos, data_in);
			end
			isq_pkg::REQ_REMOVE: begin
				if (pos >= seq_len)
					res.status = isq_pkg::STS_RANGE;
				else
					close_gap(pos);
			end
			isq_pkg::REQ_GET: begin
				if (pos >= seq_len)
					res.status = isq_pkg::STS_RANGE;
				else
					res.read_data = seq_words[pos];
			end
			default: begin
				seq_len = 0;
			end
		endcase
		res.element_count = isq_pkg::COUNT_W'(seq_len);
		return res;
	endfunction

	// Drive one request, wait for its transfer and queue the expected response
	task automatic send_req(logic [isq_pkg::REQ_W-1:0] req_type,
			logic [isq_pkg::POS_W-1:0] position, logic [isq_pkg::WORD_W-1:0] data_in,
			bit typed, seq_outcome_t want);
		seq_outcome_t predicted;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= req_type;
		req_ch.position <= position;
		req_ch.data_in  <= data_in;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (seq_len == isq_pkg::CAPACITY)
			full_hits++;
		predicted = apply_request(req_type, position, data_in);
		pending_q.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Response side: stall in random bursts while idling is on
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 15) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				stall_left = 0;
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each response transfer with the oldest expectation
	always @(posedge clk) begin : rsp_check
		seq_outcome_t got;
		seq_outcome_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = {rsp_ch.read_data, rsp_ch.status, rsp_ch.element_count};
			if (pending_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: response with nothing pending: data %h status %0d count %0d",
					$time, got.read_data, got.status, got.element_count);
			end else begin
				want = pending_q.pop_front();
				status_hits[want.status]++;
				if (got !== want) begin
					mismatch_count++;
					$display({"%0t: expected data %h status %0d count %0d, ",
						"got data %h status %0d count %0d"},
						$time, want.read_data, want.status, want.element_count,
						got.read_data, got.status, got.element_count);
				end
			end
		end
	end

	// Stimulus
	initial begin
		logic [isq_pkg::REQ_W-1:0]  req_type;
		logic [isq_pkg::POS_W-1:0]  position;
		logic [isq_pkg::WORD_W-1:0] data_in;
		bit                         grow;
		int                         pick;

		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = isq_pkg::REQ_PUSH_BACK;
		req_ch.position = '0;
		req_ch.data_in  = '0;
		seq_len         = 0;
		mismatch_count  = 0;
		full_hits       = 0;
		idle_on         = 1'b1;
		grow            = 1'b1;
		foreach (status_hits[s])
			status_hits[s] = 0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the directed table
		foreach (stim_rows[r]) begin
			for (int k = 0; k < stim_rows[r].reps; k++)
				send_req(stim_rows[r].req_type, stim_rows[r].position,
					stim_rows[r].rnd_data ? $urandom : stim_rows[r].data_in,
					stim_rows[r].typed, stim_rows[r].want);
		end

		// Random requests, swinging between filling and draining the store
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == RAND_ITEMS - CALM_ITEMS)
				idle_on = 1'b0;
			if (seq_len == 0)
				grow = 1'b1;
			else if (seq_len == isq_pkg::CAPACITY && $urandom_range(0, 3) == 0)
				grow = 1'b0;

			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				req_type = isq_pkg::REQ_CLEAR;
			end else if (pick < 50) begin
				case ($urandom_range(0, 2))
					0:       req_type = grow ? isq_pkg::REQ_PUSH_BACK : isq_pkg::REQ_POP_FRONT;
					1:       req_type = grow ? isq_pkg::REQ_PUSH_FRONT : isq_pkg::REQ_POP_BACK;
					default: req_type = grow ? isq_pkg::REQ_INSERT : isq_pkg::REQ_REMOVE;
				endcase
			end else if (pick < 75) begin
				req_type = isq_pkg::REQ_GET;
			end else begin
				req_type = isq_pkg::REQ_W'($urandom_range(0, 6));
			end

			// Mostly positions up to one past the end, sometimes any code
			if ($urandom_range(0, 9) < 7)
				position = isq_pkg::POS_W'($urandom_range(0, seq_len));
			else
				position = isq_pkg::POS_W'($urandom_range(0, 31));

			case ($urandom_range(0, 15))
				0:       data_in = '0;
				1:       data_in = '1;
				default: data_in = $urandom;
			endcase

			send_req(req_type, position, data_in, 1'b0, '0);
		end
		req_ch.valid <= 1'b0;

		// Drain outstanding responses
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Ran %0d random requests after the directed table; %0d taken on a full store.",
			RAND_ITEMS, full_hits);
		$display("Responses by status: ok %0d, empty %0d, range %0d, full %0d; mismatches %0d.",
			status_hits[isq_pkg::STS_OK], status_hits[isq_pkg::STS_EMPTY],
			status_hits[isq_pkg::STS_RANGE], status_hits[isq_pkg::STS_FULL],
			mismatch_count);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Hang guard
	initial begin
		#10_000_000;
		$display("Timeout with %0d responses still pending.", pending_q.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
hdl/isq_pkg.sv
hdl/isq_req_if.sv
hdl/isq_rsp_if.sv
hdl/isq_ctrl.sv
hdl/isq_datapath.sv
hdl/indexed_sequence_store_core.sv
tb/tb_indexed_sequence_store_core.sv
